// ----- hdl/shdm_pkg.sv -----
`timescale 1ns / 1ps
// Constants, types and step functions for the string hash directory mapper.
// No dependencies; used by string_hash_directory_mapper.
package shdm_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam int unsigned LevelBits = 6;
  localparam int unsigned KeyBits   = 2 * LevelBits;

  localparam int unsigned MulA = 31;
  localparam int unsigned ModA = 101;
  localparam int unsigned MulB = 37;
  localparam int unsigned ModB = 103;

  // Byte-lane weights 2^(8i) mod m, and the correction for a set sign bit.
  localparam int unsigned WA1  = 256 % ModA;
  localparam int unsigned WA2  = (WA1 * WA1) % ModA;
  localparam int unsigned WA3  = (WA2 * WA1) % ModA;
  localparam int unsigned WA4  = (WA3 * WA1) % ModA;
  localparam int unsigned NegA = (ModA - WA4) % ModA;
  localparam int unsigned WB1  = 256 % ModB;
  localparam int unsigned WB2  = (WB1 * WB1) % ModB;
  localparam int unsigned WB3  = (WB2 * WB1) % ModB;
  localparam int unsigned WB4  = (WB3 * WB1) % ModB;
  localparam int unsigned NegB = (ModB - WB4) % ModB;

  // Reciprocal quotient, exact for every 16-bit folded sum.
  localparam int unsigned RecipShift = 23;
  localparam int unsigned RecipA     = ((1 << RecipShift) + ModA - 1) / ModA;
  localparam int unsigned RecipB     = ((1 << RecipShift) + ModB - 1) / ModB;

  localparam int unsigned SumBits   = 16;
  localparam int unsigned RecipBits = 17;
  localparam int unsigned ProdBits  = SumBits + RecipBits;
  localparam int unsigned QuotBits  = 10;
  localparam int unsigned ResBits   = 7;
  localparam int unsigned WBits     = 7;

  typedef logic [KeyBits-1:0]   key_t;
  typedef logic [SumBits-1:0]   fold_t;
  typedef logic [QuotBits-1:0]  quot_t;
  typedef logic [ResBits-1:0]   res_t;
  typedef logic [WBits-1:0]     weight_t;
  typedef logic [RecipBits-1:0] recip_t;

  function automatic logic [31:0] crc_byte_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [31:0] mul,
                                             input logic [7:0] b);
    return (h * mul) + {24'd0, b};
  endfunction

  // Sum congruent to the signed 32-bit value, small enough for one quotient step.
  function automatic fold_t residue_fold(input logic [31:0] v, input weight_t w1,
                                         input weight_t w2, input weight_t w3,
                                         input weight_t neg);
    fold_t s;
    s = fold_t'(v[7:0]) + fold_t'(v[15:8]) * fold_t'(w1)
      + fold_t'(v[23:16]) * fold_t'(w2) + fold_t'(v[31:24]) * fold_t'(w3)
      + (v[31] ? fold_t'(neg) : fold_t'(0));
    return s;
  endfunction

  function automatic quot_t fold_quot(input fold_t x, input recip_t recip);
    logic [ProdBits-1:0] p;
    p = ProdBits'(x) * ProdBits'(recip);
    return quot_t'(p >> RecipShift);
  endfunction

  function automatic res_t fold_rem(input fold_t x, input quot_t q, input weight_t m);
    fold_t r;
    r = x - fold_t'(q) * fold_t'(m);
    return res_t'(r);
  endfunction

endpackage

// ----- hdl/string_hash_directory_mapper.sv -----
`timescale 1ns / 1ps
// Top level of the string hash directory mapper: running CRC-32 and two
// polynomial hashes, reduced to four directory indices. Uses shdm_pkg.
//
// One byte is taken per cycle while in_ready is high. The running CRC and hashes update at the edge
// that accepts the byte. The last byte of a string sends its final values into
// a four-stage pipeline (capture, byte-lane fold, reciprocal quotient,
// remainder) whose last stage is the output register. out_valid rises when the
// result reaches the output register. Each stage holds when the
// stage after it is full and stalled. Bytes keep flowing until all four stages
// hold results and the output is stalled; only then does in_ready drop.
module string_hash_directory_mapper
  import shdm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [LevelBits-1:0] level_one,
  output logic [LevelBits-1:0] level_two,
  output logic [ResBits-1:0]   level_three,
  output logic [ResBits-1:0]   level_four
);

  logic [31:0] crc_value, hash_thirty_one, hash_thirty_seven;
  logic [31:0] crc_next, hash_a_next, hash_b_next;

  logic        s1_valid, s2_valid, s3_valid;
  key_t        s1_key, s2_key, s3_key;
  logic [31:0] s1_hash_a, s1_hash_b;
  fold_t       s2_sum_a, s2_sum_b, s3_sum_a, s3_sum_b;
  quot_t       s3_quot_a, s3_quot_b;

  logic out_free, s3_free, s2_free, s1_free, accept;

  assign out_free = !out_valid || out_ready;
  assign s3_free  = !s3_valid || out_free;
  assign s2_free  = !s2_valid || s3_free;
  assign s1_free  = !s1_valid || s2_free;
  assign in_ready = s1_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    crc_next    = crc_byte_step(crc_value, data_byte);
    hash_a_next = hash_step(hash_thirty_one, 32'(MulA), data_byte);
    hash_b_next = hash_step(hash_thirty_seven, 32'(MulB), data_byte);
  end

  // running state
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_value         <= CRC_INIT;
      hash_thirty_one   <= '0;
      hash_thirty_seven <= '0;
    end else if (accept) begin
      if (last_byte) begin
        crc_value         <= CRC_INIT;
        hash_thirty_one   <= '0;
        hash_thirty_seven <= '0;
      end else begin
        crc_value         <= crc_next;
        hash_thirty_one   <= hash_a_next;
        hash_thirty_seven <= hash_b_next;
      end
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) s1_valid <= accept && last_byte;
      if (s2_free) s2_valid <= s1_valid;
      if (s3_free) s3_valid <= s2_valid;
      if (out_free) out_valid <= s3_valid;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (s1_free && accept && last_byte) begin
      s1_key    <= key_t'(crc_next ^ CRC_INIT);
      s1_hash_a <= hash_a_next;
      s1_hash_b <= hash_b_next;
    end
    if (s2_free && s1_valid) begin
      s2_key   <= s1_key;
      s2_sum_a <= residue_fold(s1_hash_a, weight_t'(WA1), weight_t'(WA2), weight_t'(WA3),
                               weight_t'(NegA));
      s2_sum_b <= residue_fold(s1_hash_b, weight_t'(WB1), weight_t'(WB2), weight_t'(WB3),
                               weight_t'(NegB));
    end
    if (s3_free && s2_valid) begin
      s3_key    <= s2_key;
      s3_sum_a  <= s2_sum_a;
      s3_sum_b  <= s2_sum_b;
      s3_quot_a <= fold_quot(s2_sum_a, recip_t'(RecipA));
      s3_quot_b <= fold_quot(s2_sum_b, recip_t'(RecipB));
    end
    if (out_free && s3_valid) begin
      level_one   <= s3_key[KeyBits-1:LevelBits];
      level_two   <= s3_key[LevelBits-1:0];
      level_three <= fold_rem(s3_sum_a, s3_quot_a, weight_t'(ModA));
      level_four  <= fold_rem(s3_sum_b, s3_quot_b, weight_t'(ModB));
    end
  end

  a_level_three_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> level_three < ResBits'(ModA))
    else $error("level_three out of range");

  a_level_four_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> level_four < ResBits'(ModB))
    else $error("level_four out of range");

  a_state_cleared : assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> crc_value == CRC_INIT && hash_thirty_one == '0
                            && hash_thirty_seven == '0)
    else $error("running state not cleared after last item");

  a_stage1_held : assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_free |=> s1_valid && $stable(s1_key))
    else $error("stalled capture stage lost its item");

endmodule
